@@ design/cffs_pkg.sv @@
package cffs_pkg;

  // configuration port
  localparam int CFG_W       = 12;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BIN_WIDTH     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BIN_HEIGHT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIENTATION   = 3'd4;

  localparam logic [CFG_W-1:0] SENSOR_SIZE_RESET = 12'd2304;
  localparam logic [CFG_W-1:0] BIN_SIZE_RESET    = 12'd36;

  // operation codes carried in s_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // field widths
  localparam int MAP_ADDR_W  = 14;
  localparam int GAIN_W      = 16;
  localparam int COORD_W     = 12;
  localparam int INTENSITY_W = 16;
  localparam int SUM_W       = 48;

  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 2;

  // gain divider: numerator is |intensity| * 2^21 + gain, padded to an even width
  localparam int GNUM_W = 38;
  localparam int GDEN_W = GAIN_W + 1;

  typedef logic signed [SUM_W-1:0] sum_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

@@ design/cffs_serial_div.sv @@
module cffs_serial_div #(
  parameter int NUM_W = 12,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  // restoring division, two quotient bits per cycle, numerator must be even width
  localparam int STEPS = NUM_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] work;
  logic [CNT_W-1:0] count;
  logic             busy;

  logic [DEN_W:0]   trial_a, trial_b, diff_a, diff_b;
  logic             ge_a, ge_b;
  logic [DEN_W-1:0] rem_a, rem_next;
  logic [NUM_W-1:0] work_next;

  always_comb begin
    trial_a   = {rem, work[NUM_W-1]};
    ge_a      = trial_a >= {1'b0, den_q};
    diff_a    = trial_a - {1'b0, den_q};
    rem_a     = ge_a ? diff_a[DEN_W-1:0] : trial_a[DEN_W-1:0];
    trial_b   = {rem_a, work[NUM_W-2]};
    ge_b      = trial_b >= {1'b0, den_q};
    diff_b    = trial_b - {1'b0, den_q};
    rem_next  = ge_b ? diff_b[DEN_W-1:0] : trial_b[DEN_W-1:0];
    // numerator bits leave at the top, quotient bits enter at the bottom
    work_next = {work[NUM_W-3:0], ge_a, ge_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(STEPS);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quot = work;

endmodule

@@ design/cluster_flat_field_sum_top.sv @@
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata (pixel/map fields), s_tuser (operation), s_tlast
// m        out  m_tvalid/m_tready  m_tdata (cluster sum), m_tuser (zero gain, clamped)
// cfg      in   cfg_we             cfg_index, cfg_data
//
// a pixel word runs the two-bit-per-cycle index dividers (6 steps), then the gain divider
// (19 steps), which is skipped if its gain is zero; a map write word needs neither
// the last pixel of a cluster adds a state to load the output register, held there while
// m_tready holds off a previous sum; s_tready is high only between words
// rst is synchronous; the gain map has no reset and no clearing pass
module cluster_flat_field_sum_top #(
  parameter int MAP_SIDE = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // map_address, map_value, pixel_x, pixel_y, intensity, zero pad
  input  logic [cffs_pkg::S_TDATA_W-1:0]   s_tdata,
  // operation
  input  logic [0:0]                       s_tuser,
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // cluster_sum
  output logic [cffs_pkg::M_TDATA_W-1:0]   m_tdata,
  // zero_gain_seen, index_clamped
  output logic [cffs_pkg::M_TUSER_W-1:0]   m_tuser,
  input  logic                             cfg_we,
  input  logic [cffs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cffs_pkg::CFG_W-1:0]       cfg_data
);

  import cffs_pkg::*;

  localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAP_SIDE);
  localparam int WIDE_W = (ADDR_W > MAP_ADDR_W) ? ADDR_W : MAP_ADDR_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_IDX  = 3'd1;
  localparam logic [2:0] ST_ADDR = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_GDIV = 3'd4;
  localparam logic [2:0] ST_ADD  = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0] state, state_next;

  // configuration
  logic [CFG_W-1:0] sensor_width, sensor_height, bin_width, bin_height;
  logic             orientation;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_width  <= SENSOR_SIZE_RESET;
      sensor_height <= SENSOR_SIZE_RESET;
      bin_width     <= BIN_SIZE_RESET;
      bin_height    <= BIN_SIZE_RESET;
      orientation   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENSOR_WIDTH:  sensor_width  <= cfg_data;
        REG_SENSOR_HEIGHT: sensor_height <= cfg_data;
        REG_BIN_WIDTH:     bin_width     <= cfg_data;
        REG_BIN_HEIGHT:    bin_height    <= cfg_data;
        REG_ORIENTATION:   orientation   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [MAP_ADDR_W-1:0]         in_map_address;
  logic [GAIN_W-1:0]             in_map_value;
  logic [COORD_W-1:0]            in_pixel_x, in_pixel_y;
  logic signed [INTENSITY_W-1:0] in_intensity;

  assign in_map_address = s_tdata[13:0];
  assign in_map_value   = s_tdata[29:14];
  assign in_pixel_x     = s_tdata[41:30];
  assign in_pixel_y     = s_tdata[53:42];
  assign in_intensity   = s_tdata[69:54];

  logic accept, accept_write, accept_pixel;

  assign s_tready     = (state == ST_IDLE);
  assign accept       = s_tvalid && s_tready;
  assign accept_write = accept && (s_tuser[0] == OP_WRITE);
  assign accept_pixel = accept && (s_tuser[0] == OP_PIXEL);

  // mirrored coordinates
  logic             over_x_in, over_y_in;
  logic [CFG_W-1:0] num_x, num_y;

  assign over_x_in = in_pixel_x > sensor_width;
  assign over_y_in = in_pixel_y > sensor_height;
  assign num_x     = over_x_in ? '0 : sensor_width - in_pixel_x;
  assign num_y     = over_y_in ? '0 : sensor_height - in_pixel_y;

  logic                          over_x, over_y, last;
  logic signed [INTENSITY_W-1:0] intensity;

  always_ff @(posedge clk) begin
    if (accept_pixel) begin
      over_x    <= over_x_in;
      over_y    <= over_y_in;
      last      <= s_tlast;
      intensity <= in_intensity;
    end
  end

  logic             x_done, y_done, idx_done;
  logic [CFG_W-1:0] quot_x, quot_y;

  cffs_serial_div #(.NUM_W(CFG_W), .DEN_W(CFG_W)) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (accept_pixel),
    .num   (num_x),
    .den   (bin_width),
    .done  (x_done),
    .quot  (quot_x)
  );

  cffs_serial_div #(.NUM_W(CFG_W), .DEN_W(CFG_W)) u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (accept_pixel),
    .num   (num_y),
    .den   (bin_height),
    .done  (y_done),
    .quot  (quot_y)
  );

  assign idx_done = x_done && y_done;

  // bin clamping; a zero bin size divides to all ones and lands in the top bin
  logic             big_x, big_y;
  logic [IDX_W-1:0] bx_next, by_next, bx, by;

  assign big_x   = !over_x && (quot_x >= CFG_W'(MAP_SIDE));
  assign big_y   = !over_y && (quot_y >= CFG_W'(MAP_SIDE));
  assign bx_next = over_x ? '0 : (big_x ? IDX_W'(MAP_SIDE - 1) : quot_x[IDX_W-1:0]);
  assign by_next = over_y ? '0 : (big_y ? IDX_W'(MAP_SIDE - 1) : quot_y[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (state == ST_IDX && idx_done) begin
      bx <= bx_next;
      by <= by_next;
    end
  end

  logic [IDX_W-1:0]  major, minor;
  logic [ADDR_W-1:0] rd_addr;

  assign major   = orientation ? bx : by;
  assign minor   = orientation ? by : bx;
  assign rd_addr = ADDR_W'(major) * ADDR_W'(MAP_SIDE) + ADDR_W'(minor);

  // gain map
  logic [GAIN_W-1:0] gain_map [DEPTH];
  logic [GAIN_W-1:0] gain;
  logic [WIDE_W-1:0] wr_wide;
  logic              wr_in_range;

  assign wr_wide     = WIDE_W'(in_map_address);
  assign wr_in_range = 32'(in_map_address) < 32'(DEPTH);

  always_ff @(posedge clk) begin
    if (accept_write && wr_in_range) begin
      gain_map[wr_wide[ADDR_W-1:0]] <= in_map_value;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ADDR) begin
      gain <= gain_map[rd_addr];
    end
  end

  // gain division: round(|i| * 2^20 / g) = (|i| * 2^21 + g) / (2 g)
  logic              neg;
  logic [15:0]       mag;
  logic [GNUM_W-1:0] gnum;
  logic [GDEN_W-1:0] gden;
  logic              gdiv_start, gdiv_done, gain_zero;
  logic [GNUM_W-1:0] gquot;

  assign neg        = intensity[INTENSITY_W-1];
  assign mag        = neg ? (~intensity + 16'd1) : intensity;
  assign gnum       = {1'b0, mag, 21'b0} + GNUM_W'(gain);
  assign gden       = {gain, 1'b0};
  assign gain_zero  = (gain == '0);
  assign gdiv_start = (state == ST_RD) && !gain_zero;

  cffs_serial_div #(.NUM_W(GNUM_W), .DEN_W(GDEN_W)) u_div_gain (
    .clk   (clk),
    .rst   (rst),
    .start (gdiv_start),
    .num   (gnum),
    .den   (gden),
    .done  (gdiv_done),
    .quot  (gquot)
  );

  sum_t contrib;
  sum_t gquot_ext;

  assign gquot_ext = SUM_W'(gquot);

  always_ff @(posedge clk) begin
    if (state == ST_RD && gain_zero) begin
      if (intensity > 0) begin
        contrib <= SUM_MAX;
      end else if (neg) begin
        contrib <= SUM_MIN;
      end else begin
        contrib <= '0;
      end
    end else if (state == ST_GDIV && gdiv_done) begin
      contrib <= neg ? -gquot_ext : gquot_ext;
    end
  end

  // saturating accumulate
  sum_t              running_sum, sum_sat;
  logic [SUM_W:0]    sum_wide;
  logic              zero_flag, clamp_flag;
  logic              out_free;

  assign sum_wide = {running_sum[SUM_W-1], running_sum} + {contrib[SUM_W-1], contrib};
  assign sum_sat  = (sum_wide[SUM_W] == sum_wide[SUM_W-1]) ? sum_wide[SUM_W-1:0]
                  : (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept_pixel) state_next = ST_IDX;
      ST_IDX:  if (idx_done) state_next = ST_ADDR;
      ST_ADDR: state_next = ST_RD;
      ST_RD:   state_next = gain_zero ? ST_ADD : ST_GDIV;
      ST_GDIV: if (gdiv_done) state_next = ST_ADD;
      ST_ADD:  state_next = last ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      running_sum <= '0;
      zero_flag   <= 1'b0;
      clamp_flag  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_IDX && idx_done && (over_x || over_y || big_x || big_y)) begin
        clamp_flag <= 1'b1;
      end
      if (state == ST_RD && gain_zero) begin
        zero_flag <= 1'b1;
      end
      if (state == ST_ADD) begin
        running_sum <= sum_sat;
      end
      if (state == ST_EMIT && out_free) begin
        running_sum <= '0;
        zero_flag   <= 1'b0;
        clamp_flag  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tdata <= running_sum;
      m_tuser <= {clamp_flag, zero_flag};
    end
  end

endmodule
